/* rtl/binary_heap_priority_queue_assert.svh */
// Assertion shorthands used by the heap queue module.
// Each one samples on clk and is switched off while arst_n is low.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Property that must hold at every clock edge.
`define BHPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition at one edge implies an expectation at the next edge.
`define BHPQ_ASSERT_NEXT(label, cond, expect_next, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (expect_next)) else $error(msg);

`endif

/* rtl/bhpq_pkg.sv */
package bhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_W    = 32;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;

	// Operation codes; the unused code behaves as a query
	localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [KEY_W-1:0]    key;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    popped_key;
		logic [KEY_W-1:0]    top_key;
		logic [COUNT_W-1:0]  entry_count;
		logic                is_empty;
	} out_item_t;

	// True when key a is served before key b under the selected ordering
	function automatic logic ranks_before(input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b, input logic smallest_first);
		return smallest_first ? (a < b) : (a > b);
	endfunction

endpackage

/* rtl/bhpq_ram.sv */
module bhpq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read two entries, data registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* rtl/binary_heap_priority_queue.sv */
// Binary-heap priority queue of up to CAPACITY 32-bit keys. Each input transfer is a push,
// a pop or a query and yields exactly one result transfer that shows the queue after the
// operation: status, popped key, top key, count and empty flag. The keys live in one
// synchronous RAM (one write port, two read ports); the root is mirrored in a register so
// the top key and popped key need no read. A push moves its key up by L levels and a pop
// moves the last key down by L levels (at most 10 on a push and 9 on a pop for 1024
// entries); a rejected push, an empty pop or a query moves no key.
// Each level compares one RAM read result and writes one entry back.
// A new transfer is taken while the previous result still waits on the output register.
// order_select (cfg_wr_data) is 0 for largest key first and 1 for smallest key first;
// write it only while the queue is idle. The RAM needs no clearing after reset.
`include "binary_heap_priority_queue_assert.svh"

module binary_heap_priority_queue
	import bhpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = AW + 2;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_UP   = 6'b000010,
		S_FIN  = 6'b000100,
		S_DNLD = 6'b001000,
		S_DN   = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       pos_q, pos_d;
	logic [KEY_W-1:0]    cur_q, cur_d;
	logic [KEY_W-1:0]    top_q;
	logic [KEY_W-1:0]    popped_q, popped_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic                order_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic                in_xfer;
	logic                out_free;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [KEY_W-1:0]    mem_wdata;
	logic [AW-1:0]       mem_raddr_a;
	logic [AW-1:0]       mem_raddr_b;
	logic [KEY_W-1:0]    mem_rdata_a;
	logic [KEY_W-1:0]    mem_rdata_b;

	logic [AW-1:0]       parent_idx;
	logic [AW-1:0]       grand_idx;
	logic [AW-1:0]       push_parent;
	logic [DW-1:0]       left_w;
	logic [DW-1:0]       right_w;
	logic [DW-1:0]       n_w;
	logic                take_right;
	logic [AW-1:0]       pick_idx;
	logic [KEY_W-1:0]    pick_val;
	logic [DW-1:0]       pick_left;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Index arithmetic for one level of sift-up and sift-down
	assign parent_idx  = (pos_q - AW'(1)) >> 1;
	assign grand_idx   = (parent_idx - AW'(1)) >> 1;
	assign push_parent = (count_q[AW-1:0] - AW'(1)) >> 1;
	assign left_w      = {1'b0, pos_q, 1'b1};
	assign right_w     = left_w + DW'(1);
	assign n_w         = DW'(count_q);
	assign take_right  = (right_w < n_w) && !ranks_before(mem_rdata_a, mem_rdata_b, order_q);
	assign pick_idx    = take_right ? right_w[AW-1:0] : left_w[AW-1:0];
	assign pick_val    = take_right ? mem_rdata_b : mem_rdata_a;
	assign pick_left   = {1'b0, pick_idx, 1'b1};

	// Sequence one operation; each level writes one entry and reads the next.
	// The entry written never coincides with an entry whose read result is used.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pos_d       = pos_q;
		cur_d       = cur_q;
		popped_d    = popped_q;
		status_d    = status_q;
		mem_we      = 1'b0;
		mem_waddr   = pos_q;
		mem_wdata   = cur_q;
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					status_d = ST_OK;
					popped_d = '0;
					state_d  = S_DONE;
					if (in_data.opcode == OP_PUSH) begin
						if (count_q == CAP_C) begin
							status_d = ST_FULL;
						end else begin
							count_d = count_q + CW'(1);
							cur_d   = in_data.key;
							pos_d   = count_q[AW-1:0];
							if (count_q == '0) begin
								mem_we    = 1'b1;
								mem_waddr = '0;
								mem_wdata = in_data.key;
							end else begin
								mem_raddr_a = push_parent;
								state_d     = S_UP;
							end
						end
					end else if (in_data.opcode == OP_POP) begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
						end else begin
							popped_d    = top_q;
							count_d     = count_q - CW'(1);
							mem_raddr_a = count_d[AW-1:0];
							state_d     = S_DNLD;
						end
					end
				end
			end
			S_UP: begin
				mem_we = 1'b1;
				if (ranks_before(cur_q, mem_rdata_a, order_q)) begin
					mem_wdata   = mem_rdata_a;
					pos_d       = parent_idx;
					mem_raddr_a = grand_idx;
					state_d     = (parent_idx == '0) ? S_FIN : S_UP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FIN: begin
				mem_we  = 1'b1;
				state_d = S_DONE;
			end
			S_DNLD: begin
				cur_d = mem_rdata_a;
				pos_d = '0;
				if (count_q == '0) begin
					state_d = S_DONE;
				end else begin
					mem_raddr_a = AW'(1);
					mem_raddr_b = AW'(2);
					state_d     = S_DN;
				end
			end
			S_DN: begin
				mem_we = 1'b1;
				if (left_w >= n_w) begin
					state_d = S_DONE;
				end else if (ranks_before(pick_val, cur_q, order_q)) begin
					mem_wdata   = pick_val;
					pos_d       = pick_idx;
					mem_raddr_a = pick_left[AW-1:0];
					mem_raddr_b = pick_left[AW-1:0] + AW'(1);
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			order_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_wr_en) begin
				order_q <= cfg_wr_data;
			end
		end
	end

	// Hold the moving key, its position, the pending result fields and the root mirror
	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		cur_q    <= cur_d;
		popped_q <= popped_d;
		status_q <= status_d;
		if (mem_we && mem_waddr == '0) begin
			top_q <= mem_wdata;
		end
	end

	// Load the result register; drop valid after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.status      <= status_q;
			out_q.popped_key  <= popped_q;
			out_q.top_key     <= (count_q != '0) ? top_q : '0;
			out_q.entry_count <= COUNT_W'(count_q);
			out_q.is_empty    <= (count_q == '0);
		end
	end

	bhpq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(KEY_W)
	) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	`BHPQ_ASSERT(a_count_bound, count_q <= CAP_C, "entry count above capacity")
	`BHPQ_ASSERT(a_pos_live, (state_q == S_UP || state_q == S_DN) |-> (CW'(pos_q) < count_q), "sift position outside live entries")
	`BHPQ_ASSERT(a_write_live, (mem_we && state_q != S_IDLE) |-> (CW'(mem_waddr) < count_q), "write outside live entries")
	`BHPQ_ASSERT_NEXT(a_pop_count, in_xfer && in_data.opcode == OP_POP && count_q != '0, count_q == $past(count_q) - CW'(1), "pop did not drop count by one")

endmodule
